FILE: hdl/hvl_pkg.sv
// Shared types and constants for the hostname line validator.
package hvl_pkg;

	localparam logic [7:0] MaxHost      = 8'd253;
	localparam logic [6:0] LabelLimit   = 7'd63;
	localparam logic [8:0] CapReset     = 9'd255;
	localparam logic [7:0] NewlineCode  = 8'h0A;
	localparam logic [7:0] DotCode      = 8'h2E;
	localparam logic [7:0] DashCode     = 8'h2D;
	localparam logic [7:0] NulCode      = 8'h00;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		status_t    status;
		logic [7:0] host_length;
	} result_t;

	function automatic logic is_alnum(input logic [7:0] b);
		is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		to_lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

endpackage

FILE: hdl/hostname_validate_line.sv
// Hostname line validator top level: input register, check logic, result register.
// A byte in the input register moves on to the result register once the result register is free,
// and its result transaction completes when out_stall is low. Throughput: one byte per cycle
// while out_stall is low; the result register loads whenever it is empty or its transaction
// completes, and the input register loads whenever it is empty or its byte moves on.
// Reset: arst_n clears the per-host state and both valid flags, and sets buffer_capacity to 255.
module hostname_validate_line import hvl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last,
	output logic [1:0] status,
	output logic [7:0] host_length
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       valid_s2;
	result_t    result_s2;
	result_t    core_result;
	logic [8:0] capacity_q;
	logic       out_free;
	logic       advance;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= CapReset;
		else if (cfg_wr_en)
			capacity_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			char_s1 <= char_code;
	end

	hvl_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.char_code       (char_s1),
		.buffer_capacity (capacity_q),
		.result          (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result while the transaction is stalled
	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= core_result;
	end

	assign out_valid   = valid_s2;
	assign out_char    = result_s2.out_char;
	assign last        = result_s2.last;
	assign status      = result_s2.status;
	assign host_length = result_s2.host_length;

endmodule

FILE: hdl/hvl_core.sv
// Per-host syntax state and the result of one byte.
module hvl_core import hvl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] char_code,
	input  logic [8:0] buffer_capacity,
	output result_t    result
);

	logic [7:0] length_q;
	logic [6:0] label_q;
	logic       prev_dash_q;
	logic       prev_dot_q;
	logic       failed_q;

	logic [7:0] length_n;
	logic [6:0] label_n;
	logic       prev_dash_n;
	logic       prev_dot_n;
	logic       failed_n;
	logic [6:0] label_inc;
	logic       is_dash;
	logic       bad;
	logic [9:0] need;

	assign is_dash   = (char_code == DashCode);
	assign label_inc = (label_q < LabelLimit + 7'd1) ? label_q + 7'd1 : label_q;
	assign bad       = failed_q || (length_q == 8'd0) || prev_dot_q || prev_dash_q;
	assign need      = {2'b00, length_q} + 10'd2;

	always_comb begin
		length_n    = length_q;
		label_n     = label_q;
		prev_dash_n = prev_dash_q;
		prev_dot_n  = prev_dot_q;
		failed_n    = failed_q;
		result      = '0;
		if (char_code == NulCode) begin
			// terminator: give the verdict, start a new host
			length_n    = '0;
			label_n     = '0;
			prev_dash_n = 1'b0;
			prev_dot_n  = 1'b0;
			failed_n    = 1'b0;
			result.out_char    = NewlineCode;
			result.last        = 1'b1;
			result.host_length = length_q;
			if (bad)
				result.status = STATUS_INVALID;
			else if (need > {1'b0, buffer_capacity})
				result.status = STATUS_RANGE;
			else
				result.status = STATUS_OK;
		end else begin
			if (length_q >= MaxHost)
				failed_n = 1'b1;
			if (length_q != 8'hFF)
				length_n = length_q + 8'd1;
			if (char_code == DotCode) begin
				if (label_q == 7'd0 || prev_dash_q)
					failed_n = 1'b1;
				label_n     = '0;
				prev_dot_n  = 1'b1;
				prev_dash_n = 1'b0;
			end else begin
				if (!is_dash && !is_alnum(char_code))
					failed_n = 1'b1;
				if (is_dash && label_q == 7'd0)
					failed_n = 1'b1;
				if (label_inc > LabelLimit)
					failed_n = 1'b1;
				label_n     = label_inc;
				prev_dash_n = is_dash;
				prev_dot_n  = 1'b0;
			end
			result.out_char    = to_lower(char_code);
			result.last        = 1'b0;
			result.status      = STATUS_OK;
			result.host_length = length_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			label_q     <= '0;
			prev_dash_q <= 1'b0;
			prev_dot_q  <= 1'b0;
			failed_q    <= 1'b0;
		end else if (advance) begin
			length_q    <= length_n;
			label_q     <= label_n;
			prev_dash_q <= prev_dash_n;
			prev_dot_q  <= prev_dot_n;
			failed_q    <= failed_n;
		end
	end

endmodule

FILE: hdl/hvl_checker.sv
// Port-level checks for the hostname line validator, bound to the top level.
module hvl_checker import hvl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       last,
	input logic [1:0] status,
	input logic [7:0] host_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last) &&
			$stable(status) && $stable(host_length))
		else $error("result changed while stalled");

	a_last_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_char == NewlineCode)
		else $error("terminator result without newline");

	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == STATUS_OK && host_length != 8'd0)
		else $error("data result with verdict or zero length");

	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && status != STATUS_INVALID |->
			host_length != 8'd0 && host_length <= MaxHost &&
			(status == STATUS_OK || status == STATUS_RANGE))
		else $error("bad verdict for host length");

endmodule

bind hostname_validate_line hvl_checker u_hvl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_char    (out_char),
	.last        (last),
	.status      (status),
	.host_length (host_length)
);

FILE: verif/tb_hostname_validate_line.sv
// Self-checking testbench for the streaming hostname validator with random stalls on both sides.
`timescale 1ns / 1ps

module tb_hostname_validate_line;
	import hvl_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'h00;
	logic       cfg_wr_en = 1'b0;
	logic [8:0] cfg_wr_data = 9'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       last;
	logic [1:0] status;
	logic [7:0] host_length;

	hostname_validate_line uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last(last),
		.status(status),
		.host_length(host_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// host bytes waiting for the driver, and the line bytes the block owes us
	logic [7:0] host_bytes_pending[$];
	logic [7:0] host_buf[$];
	result_t    expected_out[$];

	// shadow of the block's per-host state and its capacity register
	logic [8:0] cap_shadow = CapReset;
	logic [7:0] sh_length = 8'd0;
	logic [6:0] sh_label = 7'd0;
	logic       sh_prev_dash = 1'b0;
	logic       sh_prev_dot = 1'b0;
	logic       sh_failed = 1'b0;

	int  mismatches = 0;
	int  results_seen = 0;
	int  hosts_ok = 0;
	int  hosts_invalid = 0;
	int  hosts_range = 0;
	int  cap_settings = 1;
	logic in_fire = 1'b0;
	logic settle_phase = 1'b0;
	logic send_bursty = 1'b1;
	logic recv_bursty = 1'b1;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_left = 0;
	logic hold_done = 1'b0;

	function automatic result_t validate_byte(input logic [7:0] b);
		result_t r;
		logic    bad;
		r.last = 1'b0;
		r.status = STATUS_OK;
		if (b == NulCode) begin
			bad = sh_failed || sh_length == 8'd0 || sh_prev_dot || sh_prev_dash;
			r.out_char = NewlineCode;
			r.last = 1'b1;
			r.host_length = sh_length;
			if (bad) begin
				r.status = STATUS_INVALID;
				hosts_invalid++;
			end else if (int'(sh_length) + 2 > int'(cap_shadow)) begin
				r.status = STATUS_RANGE;
				hosts_range++;
			end else begin
				hosts_ok++;
			end
			sh_length = 8'd0;
			sh_label = 7'd0;
			sh_prev_dash = 1'b0;
			sh_prev_dot = 1'b0;
			sh_failed = 1'b0;
			return r;
		end
		if (sh_length >= MaxHost)
			sh_failed = 1'b1;
		if (sh_length != 8'd255)
			sh_length = sh_length + 8'd1;
		if (b == DotCode) begin
			if (sh_label == 7'd0 || sh_prev_dash)
				sh_failed = 1'b1;
			sh_label = 7'd0;
			sh_prev_dot = 1'b1;
			sh_prev_dash = 1'b0;
		end else begin
			if (b == DashCode) begin
				if (sh_label == 7'd0)
					sh_failed = 1'b1;
			end else if (!((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
					(b >= "a" && b <= "z"))) begin
				sh_failed = 1'b1;
			end
			// label length saturates one past the limit
			if (sh_label <= LabelLimit)
				sh_label = sh_label + 7'd1;
			if (sh_label > LabelLimit)
				sh_failed = 1'b1;
			sh_prev_dash = (b == DashCode);
			sh_prev_dot = 1'b0;
		end
		r.out_char = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
		r.host_length = sh_length;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// monitor: check finished transactions and predict accepted ones
	always @(posedge clk) begin : watch_ports
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					$error("unexpected result: out_char %0d last %0d", out_char, last);
					mismatches++;
				end else begin
					want = expected_out.pop_front();
					check_field("out_char", want.out_char, out_char);
					check_field("last", {7'd0, want.last}, {7'd0, last});
					check_field("status", {6'd0, want.status}, {6'd0, status});
					check_field("host_length", want.host_length, host_length);
				end
			end
			if (in_valid && !in_stall)
				expected_out.push_back(validate_byte(char_code));
		end
		in_fire <= arst_n && in_valid && !in_stall;
	end

	// driver: hold the byte until it is taken, then advance or idle
	always @(negedge clk) begin : drive_bytes
		logic       nv;
		logic [7:0] nb;
		nv = in_valid;
		nb = char_code;
		if (arst_n && (!in_valid || in_fire)) begin
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (!settle_phase && send_bursty && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 6) - 1;
			end else if (host_bytes_pending.size() > 0) begin
				nb = host_bytes_pending.pop_front();
				nv = 1'b1;
			end
		end
		if ($urandom_range(0, 63) == 0)
			send_bursty = !send_bursty;
		in_valid <= nv;
		char_code <= nb;
	end

	// receiver: random stall bursts plus one long hold so the pipeline backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen >= 400) begin
			hold_done = 1'b1;
			hold_left = 119;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else if (!settle_phase && recv_bursty && $urandom_range(0, 7) == 0) begin
			recv_gap = $urandom_range(1, 6) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
		if ($urandom_range(0, 63) == 0)
			recv_bursty = !recv_bursty;
	end

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(0, 2))
			0: return 8'(8'h30 + $urandom_range(0, 9));
			1: return 8'(8'h41 + $urandom_range(0, 25));
			default: return 8'(8'h61 + $urandom_range(0, 25));
		endcase
	endfunction

	task automatic push_label(input int n);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && i < n - 1 && $urandom_range(0, 4) == 0)
				host_buf.push_back(DashCode);
			else
				host_buf.push_back(rand_alnum());
		end
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			host_bytes_pending.push_back(s[i]);
		host_bytes_pending.push_back(NulCode);
	endtask

	task automatic queue_random_host();
		int pick;
		int n;
		int pos;
		host_buf.delete();
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			// near and past the host length limit, including the saturated count
			n = $urandom_range(250, 258);
			for (int i = 0; i < n; i++)
				host_buf.push_back((i % 64 == 63) ? DotCode : rand_alnum());
		end else if (pick < 8) begin
			push_label($urandom_range(62, 65));
			if ($urandom_range(0, 1)) begin
				host_buf.push_back(DotCode);
				push_label($urandom_range(1, 5));
			end
		end else if (pick < 90) begin
			n = $urandom_range(1, 4);
			for (int l = 0; l < n; l++) begin
				if (l > 0)
					host_buf.push_back(DotCode);
				push_label($urandom_range(1, 12));
			end
			if (pick >= 70) begin
				pos = $urandom_range(0, host_buf.size() - 1);
				case ($urandom_range(0, 3))
					0: host_buf[pos] = 8'($urandom_range(1, 255));
					1: host_buf.push_front($urandom_range(0, 1) ? DotCode : DashCode);
					2: host_buf.push_back($urandom_range(0, 1) ? DotCode : DashCode);
					default: host_buf[pos] = $urandom_range(0, 1) ? DotCode : DashCode;
				endcase
			end
		end else begin
			n = $urandom_range(0, 8);
			repeat (n) host_buf.push_back(8'($urandom_range(1, 255)));
		end
		foreach (host_buf[i])
			host_bytes_pending.push_back(host_buf[i]);
		host_bytes_pending.push_back(NulCode);
	endtask

	// wait until every byte is taken and every line byte has come back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (host_bytes_pending.size() != 0 || in_valid || expected_out.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [8:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_shadow = v;
		cap_settings++;
	endtask

	initial begin
		int cap_plan[7];
		int start_bytes;
		cap_plan = '{0, 511, 3, 2, 40, -1, 255};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed hosts under the reset capacity
		queue_text("");
		queue_text("Az09");
		queue_text(".a");
		queue_text("a-.b");
		queue_text("-");
		host_bytes_pending.push_back(8'hFF);
		host_bytes_pending.push_back(NulCode);
		queue_text("a.");
		wait_idle();

		foreach (cap_plan[p]) begin
			write_capacity(cap_plan[p] < 0 ? 9'($urandom_range(0, 511)) : 9'(cap_plan[p]));
			if (p == 6)
				settle_phase = 1'b1;
			start_bytes = 0;
			while (start_bytes < 300) begin
				queue_random_host();
				start_bytes = host_bytes_pending.size();
			end
			wait_idle();
		end

		$display("covered %0d hosts (%0d ok, %0d invalid, %0d buffer too small)",
			hosts_ok + hosts_invalid + hosts_range, hosts_ok, hosts_invalid, hosts_range);
		$display("%0d line bytes checked across %0d capacity settings", results_seen,
			cap_settings);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
